// ----- hw/rtl/ipid_pkg.sv -----
// Shared widths, codes and stage payload types for the incremental PID block.
`default_nettype none

package ipid_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ERR_W    = SAMPLE_W + 1;
  localparam int DERIV_W  = ERR_W + 1;
  localparam int SUM_W    = 21;
  localparam int GAIN_W   = 24;
  localparam int DUTY_W   = 16;
  localparam int FRAC_W   = 16;
  localparam int ACC_W    = DUTY_W + FRAC_W;
  localparam int PROD_P_W = GAIN_W + ERR_W;
  localparam int PROD_I_W = GAIN_W + SUM_W;
  localparam int PROD_D_W = GAIN_W + DERIV_W;
  localparam int INC_W    = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_I    = 3'd1,
    CFG_GAIN_D    = 3'd2,
    CFG_DUTY_FLOOR = 3'd3,
    CFG_DUTY_CEIL  = 3'd4
  } cfg_idx_t;

  localparam logic KIND_STEP  = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  typedef struct packed {
    logic                      clear;
    logic signed [ERR_W-1:0]   err;
    logic signed [SUM_W-1:0]   esum;
    logic signed [DERIV_W-1:0] deriv;
  } s1_t;

  typedef struct packed {
    logic                       clear;
    logic signed [PROD_P_W-1:0] prod_p;
    logic signed [PROD_I_W-1:0] prod_i;
    logic signed [PROD_D_W-1:0] prod_d;
  } s2_t;

  typedef struct packed {
    logic                    clear;
    logic signed [INC_W-1:0] inc;
  } s3_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [DUTY_W-1:0]        duty_floor;
    logic [DUTY_W-1:0]        duty_ceiling;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ipid_front.sv -----
// Input stage: error, saturating integral and derivative, with the loop state.
`default_nettype none

module ipid_front #(
  parameter int SAMPLE_BITS    = 16,
  parameter int INTEGRAL_LIMIT = 500000
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic                           kind,
  input  wire logic [ipid_pkg::SAMPLE_W-1:0]  target,
  input  wire logic [ipid_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic                           down_ready,
  output logic                                ready,
  output logic                                s1_valid,
  output ipid_pkg::s1_t                       s1
);

  localparam int USE_W = (SAMPLE_BITS < ipid_pkg::SAMPLE_W) ? SAMPLE_BITS : ipid_pkg::SAMPLE_W;
  localparam logic [ipid_pkg::SAMPLE_W-1:0] MASK =
    {ipid_pkg::SAMPLE_W{1'b1}} >> (ipid_pkg::SAMPLE_W - USE_W);
  localparam logic signed [ipid_pkg::SUM_W:0] LIM_HI = INTEGRAL_LIMIT[ipid_pkg::SUM_W:0];
  localparam logic signed [ipid_pkg::SUM_W:0] LIM_LO = -LIM_HI;

  logic signed [ipid_pkg::SUM_W-1:0]   error_sum;
  logic signed [ipid_pkg::ERR_W-1:0]   last_error;
  logic [ipid_pkg::SAMPLE_W-1:0]       t_m;
  logic [ipid_pkg::SAMPLE_W-1:0]       s_m;
  logic signed [ipid_pkg::ERR_W-1:0]   err;
  logic signed [ipid_pkg::SUM_W:0]     sum_wide;
  logic signed [ipid_pkg::SUM_W-1:0]   error_sum_next;
  logic signed [ipid_pkg::DERIV_W-1:0] deriv;
  logic                                accept;

  assign ready  = !s1_valid || down_ready;
  assign accept = in_valid && ready;

  always_comb begin
    t_m = target & MASK;
    s_m = sample & MASK;
    err = $signed({1'b0, t_m}) - $signed({1'b0, s_m});
    sum_wide = $signed({error_sum[ipid_pkg::SUM_W-1], error_sum})
             + $signed({{(ipid_pkg::SUM_W + 1 - ipid_pkg::ERR_W){err[ipid_pkg::ERR_W-1]}}, err});
    if (sum_wide > LIM_HI) begin
      error_sum_next = LIM_HI[ipid_pkg::SUM_W-1:0];
    end else if (sum_wide < LIM_LO) begin
      error_sum_next = LIM_LO[ipid_pkg::SUM_W-1:0];
    end else begin
      error_sum_next = sum_wide[ipid_pkg::SUM_W-1:0];
    end
    deriv = $signed({err[ipid_pkg::ERR_W-1], err})
          - $signed({last_error[ipid_pkg::ERR_W-1], last_error});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (ready) begin
        s1_valid <= in_valid;
      end
      if (accept) begin
        if (kind == ipid_pkg::KIND_RESET) begin
          error_sum  <= '0;
          last_error <= '0;
        end else begin
          error_sum  <= error_sum_next;
          last_error <= err;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.clear <= (kind == ipid_pkg::KIND_RESET);
      s1.err   <= err;
      s1.esum  <= error_sum_next;
      s1.deriv <= deriv;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ipid_mac.sv -----
// Gain products and their sum, two register stages.
`default_nettype none

module ipid_mac (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s1_valid,
  input  wire ipid_pkg::s1_t  s1,
  input  wire ipid_pkg::cfg_t cfg,
  input  wire logic           down_ready,
  output logic                ready,
  output logic                s3_valid,
  output ipid_pkg::s3_t       s3
);

  logic          s2_valid;
  ipid_pkg::s2_t s2;
  logic          ready3;
  logic signed [ipid_pkg::INC_W-1:0] inc;

  assign ready3 = !s3_valid || down_ready;
  assign ready  = !s2_valid || ready3;

  always_comb begin
    inc = $signed({{(ipid_pkg::INC_W - ipid_pkg::PROD_P_W){s2.prod_p[ipid_pkg::PROD_P_W-1]}},
                   s2.prod_p})
        + $signed({{(ipid_pkg::INC_W - ipid_pkg::PROD_I_W){s2.prod_i[ipid_pkg::PROD_I_W-1]}},
                   s2.prod_i})
        + $signed({{(ipid_pkg::INC_W - ipid_pkg::PROD_D_W){s2.prod_d[ipid_pkg::PROD_D_W-1]}},
                   s2.prod_d});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (ready) begin
        s2_valid <= s1_valid;
      end
      if (ready3) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready && s1_valid) begin
      s2.clear  <= s1.clear;
      s2.prod_p <= cfg.gain_p * s1.err;
      s2.prod_i <= cfg.gain_i * s1.esum;
      s2.prod_d <= cfg.gain_d * s1.deriv;
    end
    if (ready3 && s2_valid) begin
      s3.clear <= s2.clear;
      s3.inc   <= inc;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ipid_out.sv -----
// Output accumulator with window clamp and the result register.
`default_nettype none

module ipid_out (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s3_valid,
  input  wire ipid_pkg::s3_t                s3,
  input  wire ipid_pkg::cfg_t               cfg,
  input  wire logic                         out_stall,
  output logic                              ready,
  output logic                              out_valid,
  output logic [ipid_pkg::DUTY_W-1:0]       duty
);

  localparam int WIDE_W = ipid_pkg::INC_W + 1;

  logic [ipid_pkg::ACC_W-1:0]   drive_acc;
  logic [ipid_pkg::ACC_W-1:0]   drive_acc_next;
  logic signed [WIDE_W-1:0]     acc_sum;
  logic signed [WIDE_W-1:0]     hi;
  logic signed [WIDE_W-1:0]     lo;
  logic signed [WIDE_W-1:0]     acc_clamped;
  logic                         take;

  assign ready = !out_valid || !out_stall;
  assign take  = s3_valid && ready;

  always_comb begin
    lo = $signed({{(WIDE_W - ipid_pkg::ACC_W){1'b0}}, cfg.duty_floor,
                  {ipid_pkg::FRAC_W{1'b0}}});
    hi = $signed({{(WIDE_W - ipid_pkg::ACC_W){1'b0}}, cfg.duty_ceiling,
                  {ipid_pkg::FRAC_W{1'b0}}});
    acc_sum = $signed({{(WIDE_W - ipid_pkg::ACC_W){1'b0}}, drive_acc})
            + $signed({s3.inc[ipid_pkg::INC_W-1], s3.inc});
    acc_clamped = acc_sum;
    // ceiling first, floor last: floor wins when the window is inverted
    if (acc_clamped > hi) begin
      acc_clamped = hi;
    end
    if (acc_clamped < lo) begin
      acc_clamped = lo;
    end
    if (s3.clear) begin
      drive_acc_next = lo[ipid_pkg::ACC_W-1:0];
    end else begin
      drive_acc_next = acc_clamped[ipid_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_acc <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ready) begin
        out_valid <= s3_valid;
      end
      if (take) begin
        drive_acc <= drive_acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      duty <= drive_acc_next[ipid_pkg::ACC_W-1:ipid_pkg::FRAC_W];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/incremental_pid_with_clamps.sv -----
// Top level of the incremental PID controller with integral and output clamps.
//
// Input channel (in_valid / in_stall): one beat carries kind, target and sample.
// kind step runs one control step; kind reset clears the integral and the
// previous error and loads the output accumulator with duty_floor.
// Output channel (out_valid / out_stall): one beat carries duty for each input
// beat, in order.
// On the way from input beat to out_valid, the accepting edge loads error and
// integral, then come the gain products, the increment sum, and last the
// accumulate and clamp into the output register.
// Throughput is one beat per cycle while out_stall is low; the accumulator
// feedback closes inside the last stage, the integral one inside the first.
// Each stage advances when the stage after it is empty or moving, so a stalled
// output holds its beat while up to three more beats fill the stages behind
// it; in_stall rises only when all four are full and out_stall is high.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once;
// write only while no beat is in flight. Indexes beyond the list are dropped.
// Synchronous reset empties the pipeline, clears the integral, previous error
// and accumulator, and loads default gains of zero and a 0..65535 window.
`default_nettype none

module incremental_pid_with_clamps #(
  parameter int SAMPLE_BITS    = 16,
  parameter int INTEGRAL_LIMIT = 500000
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               kind,
  input  wire logic [ipid_pkg::SAMPLE_W-1:0]      target,
  input  wire logic [ipid_pkg::SAMPLE_W-1:0]      sample,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [ipid_pkg::DUTY_W-1:0]             duty,
  input  wire logic                               cfg_write,
  input  wire logic [ipid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ipid_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ipid_pkg::cfg_t cfg;
  ipid_pkg::s1_t  s1;
  ipid_pkg::s3_t  s3;
  logic           s1_valid;
  logic           s3_valid;
  logic           front_ready;
  logic           mac_ready;
  logic           out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p       <= '0;
      cfg.gain_i       <= '0;
      cfg.gain_d       <= '0;
      cfg.duty_floor   <= '0;
      cfg.duty_ceiling <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ipid_pkg::CFG_GAIN_P:     cfg.gain_p <= cfg_data;
        ipid_pkg::CFG_GAIN_I:     cfg.gain_i <= cfg_data;
        ipid_pkg::CFG_GAIN_D:     cfg.gain_d <= cfg_data;
        ipid_pkg::CFG_DUTY_FLOOR: cfg.duty_floor <= cfg_data[ipid_pkg::DUTY_W-1:0];
        ipid_pkg::CFG_DUTY_CEIL:  cfg.duty_ceiling <= cfg_data[ipid_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = !front_ready;

  ipid_front #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .kind       (kind),
    .target     (target),
    .sample     (sample),
    .down_ready (mac_ready),
    .ready      (front_ready),
    .s1_valid   (s1_valid),
    .s1         (s1)
  );

  ipid_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .cfg        (cfg),
    .down_ready (out_ready),
    .ready      (mac_ready),
    .s3_valid   (s3_valid),
    .s3         (s3)
  );

  ipid_out u_out (
    .clk       (clk),
    .rst       (rst),
    .s3_valid  (s3_valid),
    .s3        (s3),
    .cfg       (cfg),
    .out_stall (out_stall),
    .ready     (out_ready),
    .out_valid (out_valid),
    .duty      (duty)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ipid_checker.sv -----
// Port-level checks for the incremental PID block, bound to the top level.
`default_nettype none

module ipid_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [ipid_pkg::DUTY_W-1:0]     duty,
  input wire logic                            cfg_write,
  input wire logic [ipid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [ipid_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [2:0]                    pending;
  logic [ipid_pkg::DUTY_W-1:0]   floor_m;
  logic [ipid_pkg::DUTY_W-1:0]   ceil_m;
  logic                          in_beat;
  logic                          out_beat;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  // track beats in flight and mirror the clamp window
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      floor_m <= '0;
      ceil_m  <= '1;
    end else begin
      pending <= pending + 3'(in_beat) - 3'(out_beat);
      if (cfg_write && cfg_index == ipid_pkg::CFG_DUTY_FLOOR) begin
        floor_m <= cfg_data[ipid_pkg::DUTY_W-1:0];
      end
      if (cfg_write && cfg_index == ipid_pkg::CFG_DUTY_CEIL) begin
        ceil_m <= cfg_data[ipid_pkg::DUTY_W-1:0];
      end
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(duty))
    else $error("stalled output beat changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("output beat without an input beat in flight");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd4)
    else $error("more beats in flight than pipeline stages");

  a_window: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> duty >= floor_m && (duty <= ceil_m || duty == floor_m))
    else $error("duty outside clamp window");

endmodule

bind incremental_pid_with_clamps ipid_checker u_ipid_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .duty      (duty),
  .cfg_write (cfg_write),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);

`default_nettype wire

// ----- verif/incremental_pid_with_clamps_test.sv -----
// Self-checking bench for the incremental PID controller: duty predicted per beat, checked in order.
`timescale 1ns / 1ps

class pid_duty_tracker;
  localparam longint INTEGRAL_LIMIT = 500000;

  logic signed [ipid_pkg::GAIN_W-1:0] gain_p;
  logic signed [ipid_pkg::GAIN_W-1:0] gain_i;
  logic signed [ipid_pkg::GAIN_W-1:0] gain_d;
  logic [ipid_pkg::DUTY_W-1:0]        duty_floor;
  logic [ipid_pkg::DUTY_W-1:0]        duty_ceiling;
  longint                             error_sum;
  longint                             last_error;
  longint                             drive_acc;
  logic [ipid_pkg::DUTY_W-1:0]        duty_q[$];
  int                                 errors;

  function new();
    gain_p       = '0;
    gain_i       = '0;
    gain_d       = '0;
    duty_floor   = '0;
    duty_ceiling = '1;
    error_sum    = 0;
    last_error   = 0;
    drive_acc    = 0;
    errors       = 0;
  endfunction

  // Accumulator is left alone; a new floor only bites at the next beat.
  function void write_reg(logic [ipid_pkg::CFG_IDX_W-1:0] idx,
                          logic [ipid_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      ipid_pkg::CFG_GAIN_P:     gain_p = data;
      ipid_pkg::CFG_GAIN_I:     gain_i = data;
      ipid_pkg::CFG_GAIN_D:     gain_d = data;
      ipid_pkg::CFG_DUTY_FLOOR: duty_floor = data[ipid_pkg::DUTY_W-1:0];
      ipid_pkg::CFG_DUTY_CEIL:  duty_ceiling = data[ipid_pkg::DUTY_W-1:0];
      default: ;
    endcase
  endfunction

  function void take_sample(logic k, logic [ipid_pkg::SAMPLE_W-1:0] t,
                            logic [ipid_pkg::SAMPLE_W-1:0] s);
    longint lo;
    longint hi;
    longint err;
    longint deriv;
    longint inc;
    lo = longint'({duty_floor, 16'h0000});
    hi = longint'({duty_ceiling, 16'h0000});
    if (k == ipid_pkg::KIND_RESET) begin
      error_sum  = 0;
      last_error = 0;
      drive_acc  = lo;
    end else begin
      err = longint'(t) - longint'(s);
      error_sum += err;
      if (error_sum > INTEGRAL_LIMIT) error_sum = INTEGRAL_LIMIT;
      if (error_sum < -INTEGRAL_LIMIT) error_sum = -INTEGRAL_LIMIT;
      deriv = err - last_error;
      inc = longint'(gain_p) * err + longint'(gain_i) * error_sum
          + longint'(gain_d) * deriv;
      last_error = err;
      drive_acc += inc;
      // ceiling first, floor second: the floor wins when they cross
      if (drive_acc > hi) drive_acc = hi;
      if (drive_acc < lo) drive_acc = lo;
    end
    duty_q.push_back(drive_acc[31:16]);
  endfunction

  function void check_duty(logic [ipid_pkg::DUTY_W-1:0] got);
    logic [ipid_pkg::DUTY_W-1:0] want;
    if (duty_q.size() == 0) begin
      $display("%0t: duty beat with none expected, expected none actual %0d", $time, got);
      errors++;
    end else begin
      want = duty_q.pop_front();
      if (got !== want) begin
        $display("%0t: duty expected %0d actual %0d", $time, want, got);
        errors++;
      end
    end
  endfunction

  function int pending();
    return duty_q.size();
  endfunction
endclass

module incremental_pid_with_clamps_test;
  localparam int                             LATENCY     = 4;
  localparam int                             SETTLE      = 12;
  localparam int                             LONG_HOLD   = 120;
  localparam int                             STALL_LIMIT = 2000;
  localparam int                             NUM_SETS    = 10;
  localparam int                             SET_ITEMS   = 75;
  localparam logic [ipid_pkg::CFG_IDX_W-1:0] SPARE_INDEX = 3'd5;
  localparam logic [ipid_pkg::GAIN_W-1:0]    GAIN_MAX    = 24'h7FFFFF;
  localparam logic [ipid_pkg::GAIN_W-1:0]    GAIN_MIN    = 24'h800000;
  localparam logic [ipid_pkg::GAIN_W-1:0]    GAIN_ONE    = 24'h010000;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic                            kind;
  logic [ipid_pkg::SAMPLE_W-1:0]   target;
  logic [ipid_pkg::SAMPLE_W-1:0]   sample;
  logic                            out_valid;
  logic                            out_stall;
  logic [ipid_pkg::DUTY_W-1:0]     duty;
  logic                            cfg_write;
  logic [ipid_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ipid_pkg::CFG_DATA_W-1:0] cfg_data;

  pid_duty_tracker board;
  int              send_idle_pct;
  int              recv_stall_pct;
  logic            hold_pending;
  int              quiet_cycles;

  incremental_pid_with_clamps i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .target    (target),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .duty      (duty),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Monitor: record accepted input beats, check accepted duty beats.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.take_sample(kind, target, sample);
      if (out_valid && !out_stall) board.check_duty(duty);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("incremental_pid_with_clamps: mismatch");
        $finish;
      end
    end
  end

  // Receiver: random stall, or one long hold-off to back the pipeline up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending <= 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic k, input logic [ipid_pkg::SAMPLE_W-1:0] t,
                           input logic [ipid_pkg::SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    target   <= t;
    sample   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic random_item();
    int                            r;
    int                            near;
    logic [ipid_pkg::SAMPLE_W-1:0] t;
    r = $urandom_range(99);
    t = 16'($urandom);
    if (r < 6) begin
      send_item(ipid_pkg::KIND_RESET, t, 16'($urandom));
    end else if (r < 56) begin
      // sample within 64 of the setpoint gives a small error
      near = int'(t) + $urandom_range(128) - 64;
      if (near < 0) near = 0;
      if (near > 65535) near = 65535;
      send_item(ipid_pkg::KIND_STEP, t, near[ipid_pkg::SAMPLE_W-1:0]);
    end else if (r < 86) begin
      send_item(ipid_pkg::KIND_STEP, t, 16'($urandom));
    end else begin
      send_item(ipid_pkg::KIND_STEP, {ipid_pkg::SAMPLE_W{$urandom_range(1) == 1}},
                {ipid_pkg::SAMPLE_W{$urandom_range(1) == 1}});
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ipid_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ipid_pkg::CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    board.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [ipid_pkg::GAIN_W-1:0] gp,
                                input logic [ipid_pkg::GAIN_W-1:0] gi,
                                input logic [ipid_pkg::GAIN_W-1:0] gd,
                                input logic [ipid_pkg::DUTY_W-1:0] lo,
                                input logic [ipid_pkg::DUTY_W-1:0] hi);
    drain();
    write_reg(ipid_pkg::CFG_GAIN_P, gp);
    write_reg(ipid_pkg::CFG_GAIN_I, gi);
    write_reg(ipid_pkg::CFG_GAIN_D, gd);
    // upper data bits are don't-care for the duty registers
    write_reg(ipid_pkg::CFG_DUTY_FLOOR, {8'($urandom), lo});
    write_reg(ipid_pkg::CFG_DUTY_CEIL, {8'($urandom), hi});
    write_reg(SPARE_INDEX + 3'($urandom_range(2)), 24'($urandom));
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [ipid_pkg::GAIN_W-1:0] pick_gain(int style);
    int g;
    case (style)
      0: g = $urandom_range(8192) - 4096;
      1: g = $urandom_range(131072) - 65536;
      2: g = $urandom;
      default: begin
        case ($urandom_range(2))
          0: g = int'(GAIN_MAX);
          1: g = -8388608;
          default: g = 0;
        endcase
      end
    endcase
    return g[ipid_pkg::GAIN_W-1:0];
  endfunction

  task automatic random_settings(input int set_no);
    int                          style;
    logic [ipid_pkg::DUTY_W-1:0] a;
    logic [ipid_pkg::DUTY_W-1:0] b;
    if (set_no == 0) begin
      apply_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, 16'd0, 16'hFFFF);
    end else if (set_no == 1) begin
      apply_settings(GAIN_MIN, GAIN_MIN, GAIN_MIN, 16'hFFFF, 16'hFFFF);
    end else begin
      style = $urandom_range(3);
      a = 16'($urandom);
      b = 16'($urandom);
      case ($urandom_range(4))
        0: apply_settings(pick_gain(style), pick_gain(style), pick_gain(style), 16'd0, 16'hFFFF);
        1: apply_settings(pick_gain(style), pick_gain(style), pick_gain(style), a, a);
        2: apply_settings(pick_gain(style), pick_gain(style), pick_gain(style),
                          (a > b) ? b : a, (a > b) ? a : b);
        3: apply_settings(pick_gain(style), pick_gain(style), pick_gain(style),
                          (a > b) ? a : b, (a > b) ? b : a);
        default: apply_settings(pick_gain(style), pick_gain(style), pick_gain(style),
                                16'd0, 16'd0);
      endcase
    end
  endtask

  initial begin
    board          = new();
    clk            = 1'b0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    kind           = ipid_pkg::KIND_STEP;
    target         = '0;
    sample         = '0;
    out_stall      = 1'b0;
    cfg_write      = 1'b0;
    cfg_index      = ipid_pkg::CFG_GAIN_P;
    cfg_data       = '0;
    hold_pending   = 1'b0;
    quiet_cycles   = 0;
    send_idle_pct  = 6;
    recv_stall_pct = 54;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: saturate the integral both ways, hit both clamps, reset beats.
    apply_settings(GAIN_ONE, 24'h000100, 24'h008000, 16'd100, 16'd60000);
    send_item(ipid_pkg::KIND_RESET, 16'h0000, 16'h0000);
    repeat (8) send_item(ipid_pkg::KIND_STEP, 16'hFFFF, 16'h0000);
    send_item(ipid_pkg::KIND_RESET, 16'hFFFF, 16'hFFFF);
    repeat (8) send_item(ipid_pkg::KIND_STEP, 16'h0000, 16'hFFFF);
    send_item(ipid_pkg::KIND_STEP, 16'd1234, 16'd1234);
    send_item(ipid_pkg::KIND_STEP, 16'h0000, 16'h0000);
    send_item(ipid_pkg::KIND_STEP, 16'hFFFF, 16'hFFFF);
    // floor above ceiling: floor wins
    apply_settings(GAIN_ONE, 24'h000100, 24'h008000, 16'd50000, 16'd1000);
    send_item(ipid_pkg::KIND_STEP, 16'hFFFF, 16'h0000);
    send_item(ipid_pkg::KIND_STEP, 16'h0000, 16'hFFFF);
    send_item(ipid_pkg::KIND_RESET, 16'h1234, 16'hABCD);
    // lower the floor with the accumulator still high, no reset beat
    apply_settings(GAIN_ONE, 24'h000000, 24'h000000, 16'd0, 16'hFFFF);
    send_item(ipid_pkg::KIND_STEP, 16'd10, 16'd20);
    send_item(ipid_pkg::KIND_STEP, 16'd20, 16'd10);

    for (int set_no = 0; set_no < NUM_SETS; set_no++) begin
      random_settings(set_no);
      if (set_no < 3) begin
        send_idle_pct  = 6;
        recv_stall_pct = 54;
      end else if (set_no < 6) begin
        send_idle_pct  = 54;
        recv_stall_pct = 6;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      for (int n = 0; n < SET_ITEMS; n++) begin
        if (set_no == 7 && n == 20) hold_pending <= 1'b1;
        random_item();
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("incremental_pid_with_clamps: match");
    end else begin
      $display("incremental_pid_with_clamps: mismatch");
    end
    $finish;
  end
endmodule
